[rtl/lcar_pkg.sv]
// ============================================================================
// lcar_pkg
// Shared types, constants and microcode encoding for the load cell reader.
// ============================================================================
package lcar_pkg;

  localparam int DATA_BITS_DEF   = 24;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int RAW_W     = 24;
  localparam int DIFF_W    = RAW_W + 1;
  localparam int GPC_W     = 32;
  localparam int GPC_HALF  = GPC_W / 2;
  localparam int MOP_W     = GPC_HALF + 1;
  localparam int PP_W      = DIFF_W + MOP_W;
  localparam int PROD_W    = DIFF_W + GPC_W + 1;
  localparam int WGT_W     = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int EP_W      = 2;
  localparam int HP_W      = 8;
  localparam int SC_W      = 16;
  localparam int STEP_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_PULSES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAMS_PER    = 3'd4;

  localparam logic [EP_W-1:0]  EP_RST   = 2'd1;
  localparam logic [HP_W-1:0]  HP_RST   = 8'd1;
  localparam logic [SC_W-1:0]  SC_RST   = 16'd1;
  localparam logic [RAW_W-1:0] TARE_RST = 24'd0;
  localparam logic [GPC_W-1:0] GPC_RST  = 32'h0001_0000;

  localparam logic [WGT_W-1:0] WGT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [WGT_W-1:0] WGT_MIN = 48'h8000_0000_0000;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_FETCH  = 4'd0;
  localparam step_t S_TICK   = 4'd1;
  localparam step_t S_TEST   = 4'd2;
  localparam step_t S_DIV    = 4'd3;
  localparam step_t S_SIGN   = 4'd4;
  localparam step_t S_DIFF   = 4'd5;
  localparam step_t S_MUL_LO = 4'd6;
  localparam step_t S_MUL_HI = 4'd7;
  localparam step_t S_SAT    = 4'd8;
  localparam step_t S_EMIT   = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TICK,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SIGN,
    OP_DIFF,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SAT
  } op_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_INPUT,
    JC_NOT_FINISH,
    JC_DIV_MORE,
    JC_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    op_t    op;
    logic   take;
    logic   emit;
    jcond_t hold;
    jcond_t jc;
    step_t  target;
  } ctrl_t;

  typedef struct packed {
    logic finish;
    logic div_more;
  } dp_stat_t;

  typedef struct packed {
    logic     in_valid;
    logic     out_free;
    dp_stat_t dp;
  } cond_t;

  typedef struct packed {
    logic             clock_line;
    logic             busy;
    logic             valid;
    logic [RAW_W-1:0] raw;
    logic [WGT_W-1:0] weight;
  } res_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WAIT  = 3'b010,
    PH_SHIFT = 3'b100
  } phase_t;

endpackage

[rtl/lcar_sequencer.sv]
// ============================================================================
// lcar_sequencer
// Step counter and control store; holds, jumps or advances each cycle.
// ============================================================================
module lcar_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  lcar_pkg::cond_t cond,
  output lcar_pkg::ctrl_t ctrl
);

  lcar_pkg::step_t step;
  lcar_pkg::step_t step_next;

  function automatic lcar_pkg::ctrl_t rom(lcar_pkg::step_t s);
    lcar_pkg::ctrl_t c;
    c.op     = lcar_pkg::OP_NOP;
    c.take   = 1'b0;
    c.emit   = 1'b0;
    c.hold   = lcar_pkg::JC_NEVER;
    c.jc     = lcar_pkg::JC_NEVER;
    c.target = lcar_pkg::S_FETCH;
    unique case (s)
      lcar_pkg::S_FETCH: begin
        c.take = 1'b1;
        c.hold = lcar_pkg::JC_NO_INPUT;
      end
      lcar_pkg::S_TICK:   c.op = lcar_pkg::OP_TICK;
      lcar_pkg::S_TEST: begin
        c.op     = lcar_pkg::OP_DIV_INIT;
        c.jc     = lcar_pkg::JC_NOT_FINISH;
        c.target = lcar_pkg::S_EMIT;
      end
      lcar_pkg::S_DIV: begin
        c.op   = lcar_pkg::OP_DIV_STEP;
        c.hold = lcar_pkg::JC_DIV_MORE;
      end
      lcar_pkg::S_SIGN:   c.op = lcar_pkg::OP_SIGN;
      lcar_pkg::S_DIFF:   c.op = lcar_pkg::OP_DIFF;
      lcar_pkg::S_MUL_LO: c.op = lcar_pkg::OP_MUL_LO;
      lcar_pkg::S_MUL_HI: c.op = lcar_pkg::OP_MUL_HI;
      lcar_pkg::S_SAT:    c.op = lcar_pkg::OP_SAT;
      lcar_pkg::S_EMIT: begin
        c.emit   = 1'b1;
        c.hold   = lcar_pkg::JC_OUT_BUSY;
        c.jc     = lcar_pkg::JC_ALWAYS;
        c.target = lcar_pkg::S_FETCH;
      end
      default: c.jc = lcar_pkg::JC_ALWAYS;
    endcase
    return c;
  endfunction

  function automatic logic test(lcar_pkg::jcond_t j, lcar_pkg::cond_t st);
    logic r;
    unique case (j)
      lcar_pkg::JC_ALWAYS:     r = 1'b1;
      lcar_pkg::JC_NO_INPUT:   r = !st.in_valid;
      lcar_pkg::JC_NOT_FINISH: r = !st.dp.finish;
      lcar_pkg::JC_DIV_MORE:   r = st.dp.div_more;
      lcar_pkg::JC_OUT_BUSY:   r = !st.out_free;
      default:                 r = 1'b0;
    endcase
    return r;
  endfunction

  assign ctrl = rom(step);

  always_comb begin
    if (test(ctrl.hold, cond)) begin
      step_next = step;
    end else if (test(ctrl.jc, cond)) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + lcar_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lcar_pkg::S_FETCH;
    end else begin
      step <= step_next;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= lcar_pkg::S_EMIT)
    else $error("step beyond end of program");

endmodule

[rtl/lcar_datapath.sv]
// ============================================================================
// lcar_datapath
// Serial interface state, accumulator, restoring divider and split multiplier.
// ============================================================================
module lcar_datapath #(
  parameter int DATA_BITS   = lcar_pkg::DATA_BITS_DEF,
  parameter int COUNT_WIDTH = lcar_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lcar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcar_pkg::CFG_W-1:0]     cfg_data,
  input  lcar_pkg::ctrl_t                ctrl,
  input  logic                           take_fire,
  input  logic                           start_req,
  input  logic                           data_line,
  output lcar_pkg::dp_stat_t             stat,
  output lcar_pkg::res_t                 res
);

  localparam int ACC_W = DATA_BITS + COUNT_WIDTH;
  localparam int BC_W  = $clog2(DATA_BITS + 4);
  localparam int DC_W  = $clog2(ACC_W + 1);
  localparam int SAT_W = lcar_pkg::PROD_W - lcar_pkg::WGT_W + 1;

  // configuration
  logic [lcar_pkg::EP_W-1:0]         extra_pulses;
  logic [lcar_pkg::HP_W-1:0]         half_period;
  logic [lcar_pkg::SC_W-1:0]         sample_count;
  logic signed [lcar_pkg::RAW_W-1:0] tare;
  logic [lcar_pkg::GPC_W-1:0]        gpc;

  // control state
  lcar_pkg::phase_t         phase, phase_next;
  logic [BC_W-1:0]          bit_cnt, bit_cnt_next;
  logic [lcar_pkg::HP_W-1:0] tick_cnt, tick_cnt_next;
  logic [DATA_BITS-1:0]     shift_word, shift_word_next;
  logic signed [ACC_W-1:0]  sum, sum_next;
  logic [COUNT_WIDTH-1:0]   samples, samples_next;
  logic                     clk_lvl, clk_lvl_next;
  logic                     finish, finish_next;

  // working registers
  logic                     start_q, data_q;
  logic [ACC_W-1:0]         div_q, div_q_next;
  logic [COUNT_WIDTH-1:0]   div_r, div_r_next;
  logic                     div_neg, div_neg_next;
  logic [DC_W-1:0]          div_cnt, div_cnt_next;
  logic signed [lcar_pkg::RAW_W-1:0]  avg, avg_next;
  logic signed [lcar_pkg::DIFF_W-1:0] diff, diff_next;
  logic signed [lcar_pkg::PROD_W-1:0] prod, prod_next;
  logic [lcar_pkg::WGT_W-1:0]         weight, weight_next;

  // combinational helpers
  logic [lcar_pkg::HP_W-1:0] hp_eff;
  logic [lcar_pkg::EP_W-1:0] ep_eff;
  logic [COUNT_WIDTH-1:0]    n_eff;
  logic [lcar_pkg::HP_W-1:0] tick_inc;
  logic [BC_W-1:0]           bit_inc;
  logic [BC_W-1:0]           bit_limit;
  logic [COUNT_WIDTH-1:0]    samples_inc;
  logic [COUNT_WIDTH:0]      div_sh;
  logic [COUNT_WIDTH:0]      n_ext;
  logic [lcar_pkg::RAW_W-1:0] q_mag;
  logic signed [lcar_pkg::MOP_W-1:0] mop;
  logic signed [lcar_pkg::PP_W-1:0]  pp;
  logic [SAT_W-1:0]          prod_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      extra_pulses <= lcar_pkg::EP_RST;
      half_period  <= lcar_pkg::HP_RST;
      sample_count <= lcar_pkg::SC_RST;
      tare         <= lcar_pkg::TARE_RST;
      gpc          <= lcar_pkg::GPC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcar_pkg::CFG_EXTRA_PULSES: extra_pulses <= cfg_data[lcar_pkg::EP_W-1:0];
        lcar_pkg::CFG_HALF_PERIOD:  half_period  <= cfg_data[lcar_pkg::HP_W-1:0];
        lcar_pkg::CFG_SAMPLE_COUNT: sample_count <= cfg_data[lcar_pkg::SC_W-1:0];
        lcar_pkg::CFG_TARE_OFFSET:  tare         <= cfg_data[lcar_pkg::RAW_W-1:0];
        lcar_pkg::CFG_GRAMS_PER:    gpc          <= cfg_data[lcar_pkg::GPC_W-1:0];
        default: ;
      endcase
    end
  end

  assign hp_eff      = (half_period == '0) ? lcar_pkg::HP_W'(1) : half_period;
  assign ep_eff      = (extra_pulses == '0) ? lcar_pkg::EP_W'(1) : extra_pulses;
  assign n_eff       = (sample_count[COUNT_WIDTH-1:0] == '0) ? COUNT_WIDTH'(1)
                                                            : sample_count[COUNT_WIDTH-1:0];
  assign tick_inc    = tick_cnt + lcar_pkg::HP_W'(1);
  assign bit_inc     = bit_cnt + BC_W'(1);
  assign bit_limit   = BC_W'(DATA_BITS) + BC_W'(ep_eff);
  assign samples_inc = samples + COUNT_WIDTH'(1);
  assign div_sh      = {div_r, div_q[ACC_W-1]};
  assign n_ext       = {1'b0, n_eff};
  assign q_mag       = lcar_pkg::RAW_W'(div_q);
  assign mop         = (ctrl.op == lcar_pkg::OP_MUL_HI)
                       ? {1'b0, gpc[lcar_pkg::GPC_W-1:lcar_pkg::GPC_HALF]}
                       : {1'b0, gpc[lcar_pkg::GPC_HALF-1:0]};
  assign pp          = diff * mop;
  assign prod_top    = prod[lcar_pkg::PROD_W-1:lcar_pkg::WGT_W-1];

  always_comb begin
    phase_next      = phase;
    bit_cnt_next    = bit_cnt;
    tick_cnt_next   = tick_cnt;
    shift_word_next = shift_word;
    sum_next        = sum;
    samples_next    = samples;
    clk_lvl_next    = clk_lvl;
    finish_next     = finish;
    div_q_next      = div_q;
    div_r_next      = div_r;
    div_neg_next    = div_neg;
    div_cnt_next    = div_cnt;
    avg_next        = avg;
    diff_next       = diff;
    prod_next       = prod;
    weight_next     = weight;
    unique case (ctrl.op)
      lcar_pkg::OP_TICK: begin
        finish_next = 1'b0;
        unique case (phase)
          lcar_pkg::PH_IDLE: begin
            clk_lvl_next = 1'b0;
            if (start_q) begin
              sum_next     = '0;
              samples_next = '0;
              phase_next   = lcar_pkg::PH_WAIT;
            end
          end
          lcar_pkg::PH_WAIT: begin
            clk_lvl_next = 1'b0;
            if (!data_q) begin
              phase_next      = lcar_pkg::PH_SHIFT;
              clk_lvl_next    = 1'b1;
              tick_cnt_next   = '0;
              bit_cnt_next    = '0;
              shift_word_next = '0;
            end
          end
          lcar_pkg::PH_SHIFT: begin
            if (tick_inc >= hp_eff || tick_inc == '0) begin
              tick_cnt_next = '0;
              if (clk_lvl) begin
                if (bit_cnt < BC_W'(DATA_BITS)) begin
                  shift_word_next = {shift_word[DATA_BITS-2:0], data_q};
                end
                clk_lvl_next = 1'b0;
              end else if (bit_inc >= bit_limit) begin
                sum_next     = sum + ACC_W'(signed'(shift_word));
                samples_next = samples_inc;
                bit_cnt_next = '0;
                if (samples_inc >= n_eff || samples_inc == '0) begin
                  finish_next = 1'b1;
                  phase_next  = lcar_pkg::PH_IDLE;
                end else begin
                  phase_next  = lcar_pkg::PH_WAIT;
                end
              end else begin
                bit_cnt_next = bit_inc;
                clk_lvl_next = 1'b1;
              end
            end else begin
              tick_cnt_next = tick_inc;
            end
          end
          default: begin
            phase_next   = lcar_pkg::PH_IDLE;
            clk_lvl_next = 1'b0;
          end
        endcase
      end
      lcar_pkg::OP_DIV_INIT: begin
        div_q_next   = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
        div_r_next   = '0;
        div_neg_next = sum[ACC_W-1];
        div_cnt_next = DC_W'(ACC_W);
      end
      lcar_pkg::OP_DIV_STEP: begin
        div_cnt_next = div_cnt - DC_W'(1);
        if (div_sh >= n_ext) begin
          div_r_next = COUNT_WIDTH'(div_sh - n_ext);
          div_q_next = {div_q[ACC_W-2:0], 1'b1};
        end else begin
          div_r_next = div_sh[COUNT_WIDTH-1:0];
          div_q_next = {div_q[ACC_W-2:0], 1'b0};
        end
      end
      lcar_pkg::OP_SIGN:   avg_next  = div_neg ? -q_mag : q_mag;
      lcar_pkg::OP_DIFF:   diff_next = lcar_pkg::DIFF_W'(avg) - lcar_pkg::DIFF_W'(tare);
      lcar_pkg::OP_MUL_LO: prod_next = lcar_pkg::PROD_W'(pp);
      lcar_pkg::OP_MUL_HI: prod_next = prod + (lcar_pkg::PROD_W'(pp) <<< lcar_pkg::GPC_HALF);
      lcar_pkg::OP_SAT: begin
        if ((&prod_top) || !(|prod_top)) begin
          weight_next = prod[lcar_pkg::WGT_W-1:0];
        end else begin
          weight_next = prod[lcar_pkg::PROD_W-1] ? lcar_pkg::WGT_MIN : lcar_pkg::WGT_MAX;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= lcar_pkg::PH_IDLE;
      bit_cnt    <= '0;
      tick_cnt   <= '0;
      shift_word <= '0;
      sum        <= '0;
      samples    <= '0;
      clk_lvl    <= 1'b0;
      finish     <= 1'b0;
    end else begin
      phase      <= phase_next;
      bit_cnt    <= bit_cnt_next;
      tick_cnt   <= tick_cnt_next;
      shift_word <= shift_word_next;
      sum        <= sum_next;
      samples    <= samples_next;
      clk_lvl    <= clk_lvl_next;
      finish     <= finish_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_fire) begin
      start_q <= start_req;
      data_q  <= data_line;
    end
    div_q   <= div_q_next;
    div_r   <= div_r_next;
    div_neg <= div_neg_next;
    div_cnt <= div_cnt_next;
    avg     <= avg_next;
    diff    <= diff_next;
    prod    <= prod_next;
    weight  <= weight_next;
  end

  assign stat.finish   = finish;
  assign stat.div_more = (div_cnt != DC_W'(1));

  assign res.clock_line = clk_lvl;
  assign res.busy       = (phase != lcar_pkg::PH_IDLE);
  assign res.valid      = finish;
  assign res.raw        = finish ? avg : '0;
  assign res.weight     = finish ? weight : '0;

  a_clk_in_shift: assert property (@(posedge clk) disable iff (rst)
    clk_lvl |-> phase == lcar_pkg::PH_SHIFT)
    else $error("clock line high outside shift phase");

  a_bit_bound: assert property (@(posedge clk) disable iff (rst)
    bit_cnt <= BC_W'(DATA_BITS + 3))
    else $error("bit counter past last gain pulse");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    finish |-> phase == lcar_pkg::PH_IDLE)
    else $error("measurement finished but not idle");

endmodule

[rtl/load_cell_adc_reader_averager_core.sv]
// ============================================================================
// load_cell_adc_reader_averager_core
// Two-wire bridge converter reader with signed averaging and weight output.
// Each item is one tick and gives one result item.
// Plain tick: TICK, TEST, then EMIT, which holds while the output is stalled.
// Completing tick: TEST, then DIV repeats as the one-bit-per-cycle restoring
// divider, then SIGN, DIFF, two multiplier passes, SAT and EMIT.
// Synchronous reset restores config and control state only; no clearing pass.
// ============================================================================
module load_cell_adc_reader_averager_core #(
  parameter int DATA_BITS   = lcar_pkg::DATA_BITS_DEF,
  parameter int COUNT_WIDTH = lcar_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lcar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcar_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              start_req,
  input  logic                              data_line,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              clock_line,
  output logic                              busy_res,
  output logic                              result_valid,
  output logic signed [lcar_pkg::RAW_W-1:0] raw_average,
  output logic signed [lcar_pkg::WGT_W-1:0] weight_q16
);

  lcar_pkg::ctrl_t    ctrl;
  lcar_pkg::cond_t    cond;
  lcar_pkg::dp_stat_t stat;
  lcar_pkg::res_t     res;
  logic               out_free;
  logic               take_fire;
  logic               emit_fire;

  assign out_free  = !out_valid || !out_stall;
  assign take_fire = ctrl.take && in_valid;
  assign emit_fire = ctrl.emit && out_free;
  assign in_stall  = !ctrl.take;

  assign cond.in_valid = in_valid;
  assign cond.out_free = out_free;
  assign cond.dp       = stat;

  lcar_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctrl (ctrl)
  );

  lcar_datapath #(
    .DATA_BITS   (DATA_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .take_fire (take_fire),
    .start_req (start_req),
    .data_line (data_line),
    .stat      (stat),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      clock_line   <= res.clock_line;
      busy_res     <= res.busy;
      result_valid <= res.valid;
      raw_average  <= res.raw;
      weight_q16   <= res.weight;
    end
  end

endmodule
